// ===== sv/tkdc_pkg.sv =====
// Shared types and constants for the top-k by divisor count block.
`default_nettype none

package tkdc_pkg;

  localparam int KEEP_MAX    = 16;
  localparam int NUMBER_BITS = 20;
  localparam int HELD_W      = $clog2(KEEP_MAX + 1);
  localparam int KEEP_W      = 5;
  localparam int CMP_W       = (HELD_W > KEEP_W) ? HELD_W : KEEP_W;
  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(10);

  typedef struct packed {
    logic [19:0] number;
    logic [7:0]  factor_count;
    logic        last_number;
  } item_t;

  typedef struct packed {
    logic [19:0] kept_number;
    logic [7:0]  kept_factor_count;
    logic        report_end;
  } result_t;

  typedef struct packed {
    logic [NUMBER_BITS-1:0] num;
    logic [7:0]             cnt;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift_up;
  } cell_ctl_t;

  typedef struct packed {
    logic live;
    logic lim;
    logic tail;
  } cell_pos_t;

  typedef struct packed {
    logic above;
    logic hit;
    logic beats;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== sv/top_k_by_divisor_count.sv =====
// Top level: keeps the highest-ranked numbers by factor count in a sorted cell chain.
// An item that is not marked last is taken in its accept cycle; start may be high again next cycle.
// A last-marked item is ranked in its accept cycle like any other, then the held entries stream out,
// one per cycle, while busy stays high until the last held entry is out.
// The report shifts the chain toward cell zero; the receiver cannot stall it.
// Reset empties the chain and sets keep_count to 10; entry contents are not cleared.
`default_nettype none

module top_k_by_divisor_count (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  tkdc_pkg::item_t               item_i,
  output logic                          result_strobe_o,
  output tkdc_pkg::result_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [tkdc_pkg::KEEP_W-1:0]   cfg_wdata_i
);
  import tkdc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_e;

  state_e             state_q, state_d;
  logic [HELD_W-1:0]  held_q, held_d;
  logic [KEEP_W-1:0]  keep_q, keep_d;

  entry_t     new_entry;
  entry_t     entries  [KEEP_MAX];
  cell_stat_t stats    [KEEP_MAX];
  cell_pos_t  pos      [KEEP_MAX];
  logic [KEEP_MAX-1:0] hit_vec, beats_vec;

  logic [CMP_W-1:0]  eff_keep;
  logic              full, dup, beats_tail, accept, insert;
  logic [HELD_W-1:0] limit;
  cell_ctl_t         ctl;

  assign new_entry.num = item_i.number[NUMBER_BITS-1:0];
  assign new_entry.cnt = item_i.factor_count;

  always_comb begin
    if (keep_q == '0) begin
      eff_keep = CMP_W'(1);
    end else if (CMP_W'(keep_q) > CMP_W'(KEEP_MAX)) begin
      eff_keep = CMP_W'(KEEP_MAX);
    end else begin
      eff_keep = CMP_W'(keep_q);
    end
  end

  assign full  = CMP_W'(held_q) >= eff_keep;
  assign limit = full ? (held_q - HELD_W'(1)) : held_q;

  genvar g;
  generate
    for (g = 0; g < KEEP_MAX; g++) begin : g_cell
      assign pos[g].live = HELD_W'(g) < held_q;
      assign pos[g].lim  = HELD_W'(g) < limit;
      assign pos[g].tail = held_q == HELD_W'(g + 1);
      assign hit_vec[g]   = stats[g].hit;
      assign beats_vec[g] = stats[g].beats;

      if (g == 0) begin : g_head
        tkdc_cell u_cell (
          .clk_i       (clk_i),
          .new_i       (new_entry),
          .prev_i      (new_entry),
          .prev_above_i(1'b0),
          .next_i      (entries[g + 1 < KEEP_MAX ? g + 1 : g]),
          .pos_i       (pos[g]),
          .ctl_i       (ctl),
          .entry_o     (entries[g]),
          .stat_o      (stats[g])
        );
      end else begin : g_body
        tkdc_cell u_cell (
          .clk_i       (clk_i),
          .new_i       (new_entry),
          .prev_i      (entries[g - 1]),
          .prev_above_i(stats[g - 1].above),
          .next_i      (entries[g + 1 < KEEP_MAX ? g + 1 : g]),
          .pos_i       (pos[g]),
          .ctl_i       (ctl),
          .entry_o     (entries[g]),
          .stat_o      (stats[g])
        );
      end
    end
  endgenerate

  assign dup        = |hit_vec;
  assign beats_tail = |beats_vec;
  assign accept     = start && (state_q == ST_IDLE);
  assign insert     = accept && !dup && (!full || beats_tail);

  assign ctl.insert   = insert;
  assign ctl.shift_up = (state_q == ST_REPORT);

  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    keep_d  = keep_q;
    if (cfg_we_i) begin
      keep_d = cfg_wdata_i;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (insert && !full) begin
          held_d = held_q + HELD_W'(1);
        end
        if (accept && item_i.last_number) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        held_d = held_q - HELD_W'(1);
        if (held_q == HELD_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q  <= '0;
      keep_q  <= KEEP_RESET;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      keep_q  <= keep_d;
    end
  end

  assign busy                       = (state_q == ST_REPORT);
  assign result_strobe_o            = (state_q == ST_REPORT);
  assign result_o.kept_number       = 20'(entries[0].num);
  assign result_o.kept_factor_count = entries[0].cnt;
  assign result_o.report_end        = (held_q == HELD_W'(1));

endmodule

`default_nettype wire

// ===== sv/tkdc_cell.sv =====
// One slot of the sorted insertion chain: holds an entry and ranks the offered item against it.
`default_nettype none

module tkdc_cell (
  input  logic               clk_i,
  input  tkdc_pkg::entry_t   new_i,
  input  tkdc_pkg::entry_t   prev_i,
  input  logic               prev_above_i,
  input  tkdc_pkg::entry_t   next_i,
  input  tkdc_pkg::cell_pos_t pos_i,
  input  tkdc_pkg::cell_ctl_t ctl_i,
  output tkdc_pkg::entry_t   entry_o,
  output tkdc_pkg::cell_stat_t stat_o
);
  import tkdc_pkg::*;

  entry_t entry_q, entry_d;
  logic   above;

  assign above = !pos_i.lim || (new_i.cnt > entry_q.cnt) ||
                 ((new_i.cnt == entry_q.cnt) && (new_i.num > entry_q.num));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift_up) begin
      entry_d = next_i;
    end else if (ctl_i.insert && above) begin
      entry_d = prev_above_i ? prev_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign stat_o.above = above;
  assign stat_o.hit   = pos_i.live && (entry_q.num == new_i.num);
  assign stat_o.beats = pos_i.tail && (new_i.cnt > entry_q.cnt);

endmodule

`default_nettype wire

// ===== test/tkdc_report_checker.sv =====
// Checker for top_k_by_divisor_count: tracks the ranked list, predicts reports, compares results.
`timescale 1ns / 100ps

module tkdc_report_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  tkdc_pkg::item_t             item_i,
  input  logic                        strobe_i,
  input  tkdc_pkg::result_t           result_i,
  input  logic                        cfg_we_i,
  input  logic [tkdc_pkg::KEEP_W-1:0] cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o
);

  import tkdc_pkg::*;

  entry_t            ranked [KEEP_MAX];
  int                held;
  logic [KEEP_W-1:0] keep_reg;
  result_t           report_due [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic bit outranks(entry_t a, entry_t b);
    return a.cnt > b.cnt || (a.cnt == b.cnt && a.num > b.num);
  endfunction

  task automatic place_entry(input entry_t e);
    int pos;
    pos = 0;
    while (pos < held && !outranks(e, ranked[pos])) pos++;
    for (int i = held; i > pos; i--) ranked[i] = ranked[i-1];
    ranked[pos] = e;
    held++;
  endtask

  task automatic absorb_item(input item_t it);
    entry_t  e;
    bit      dup;
    int      lim;
    result_t r;
    e.num = it.number;
    e.cnt = it.factor_count;
    dup   = 1'b0;
    for (int i = 0; i < held; i++)
      if (ranked[i].num == e.num) dup = 1'b1;
    lim = (keep_reg == 0) ? 1 : (keep_reg > KEEP_MAX) ? KEEP_MAX : int'(keep_reg);
    if (!dup) begin
      if (held < lim) begin
        place_entry(e);
      end else if (held > 0 && e.cnt > ranked[held-1].cnt) begin
        held--;
        place_entry(e);
      end
    end
    if (it.last_number) begin
      for (int i = 0; i < held; i++) begin
        r.kept_number       = ranked[i].num;
        r.kept_factor_count = ranked[i].cnt;
        r.report_end        = (i == held - 1);
        report_due.push_back(r);
      end
      held = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      held     = 0;
      keep_reg = KEEP_RESET;
      report_due.delete();
    end else begin
      if (strobe_i === 1'b1) begin
        if (report_due.size() == 0) begin
          flag_mismatch("unexpected result", 32'(result_i), 32'(0));
        end else begin
          want = report_due.pop_front();
          checked_o++;
          if (result_i.kept_number !== want.kept_number)
            flag_mismatch("kept_number", 32'(result_i.kept_number),
                          32'(want.kept_number));
          if (result_i.kept_factor_count !== want.kept_factor_count)
            flag_mismatch("kept_factor_count", 32'(result_i.kept_factor_count),
                          32'(want.kept_factor_count));
          if (result_i.report_end !== want.report_end)
            flag_mismatch("report_end", 32'(result_i.report_end),
                          32'(want.report_end));
        end
      end else if (strobe_i !== 1'b0) begin
        flag_mismatch("result strobe unknown", 32'(strobe_i), 32'(0));
      end
      if (start_i && !busy_i) absorb_item(item_i);
      if (cfg_we_i) keep_reg = cfg_wdata_i;
    end
    pending_o = report_due.size();
  end

endmodule

// ===== test/top_k_by_divisor_count_tb.sv =====
// Testbench top for top_k_by_divisor_count: reset, keep_count settings, item stimulus, verdict.
`timescale 1ns / 100ps

module top_k_by_divisor_count_tb;

  import tkdc_pkg::*;

  localparam int SETTLE = 2 * KEEP_MAX + 4;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  item_t             item_i;
  logic              result_strobe_o;
  result_t           result_o;
  logic              cfg_we_i;
  logic [KEEP_W-1:0] cfg_wdata_i;

  int fail_count;
  int pending;
  int checked;
  int items_sent;
  int reports_sent;
  int keep_writes;
  int burst_left;
  bit steady;

  top_k_by_divisor_count DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .item_i          (item_i),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  tkdc_report_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item_i),
    .strobe_i     (result_strobe_o),
    .result_i     (result_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #500us;
    $display("timeout with %0d results outstanding", pending);
    $display("top_k_by_divisor_count_tb NOT OK");
    $finish;
  end

  task automatic offer(input logic [19:0] n, input logic [7:0] c, input logic l);
    int gap;
    start  <= 1'b1;
    item_i <= {n, c, l};
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (l) reports_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 10);
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    keep_writes++;
  endtask

  initial begin : stimulus
    int                len;
    bit                tight;
    bit                ties;
    bit                closes;
    logic [19:0]       n;
    logic [7:0]        c;
    logic              l;
    logic [KEEP_W-1:0] k;
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    items_sent   = 0;
    reports_sent = 0;
    keep_writes  = 0;
    burst_left   = 0;
    steady       = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_keep(5'd3);
    offer(20'h00000, 8'd0, 1'b0);
    offer(20'hFFFFF, 8'd255, 1'b0);
    offer(20'h00005, 8'd7, 1'b0);
    offer(20'h00005, 8'd200, 1'b0);
    offer(20'h00009, 8'd7, 1'b0);
    offer(20'h0000C, 8'd7, 1'b0);
    offer(20'h00001, 8'd8, 1'b1);

    write_keep(5'd0);
    offer(20'd100, 8'd3, 1'b0);
    offer(20'd200, 8'd3, 1'b0);
    offer(20'd300, 8'd4, 1'b1);

    write_keep(5'd31);
    for (int i = 0; i < 16; i++) offer(20'(i * 3 + 1), 8'(i % 4), i == 15);

    steady     = 1'b0;
    burst_left = $urandom_range(0, 8);
    while (items_sent < 160) begin
      case ($urandom_range(0, 5))
        0:       k = 5'd0;
        1:       k = 5'd1;
        2:       k = 5'd16;
        3:       k = 5'($urandom_range(17, 31));
        default: k = 5'($urandom_range(2, 15));
      endcase
      write_keep(k);
      steady = ($urandom_range(0, 3) == 0);
      len    = $urandom_range(1, 20);
      tight  = ($urandom_range(0, 2) == 0);
      ties   = ($urandom_range(0, 2) == 0);
      closes = ($urandom_range(0, 4) != 0);
      for (int j = 0; j < len; j++) begin
        n = tight ? 20'($urandom_range(0, 15)) : 20'($urandom_range(0, 20'hFFFFF));
        c = ties ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        l = (j == len - 1 && closes) || ($urandom_range(0, 15) == 0);
        offer(n, c, l);
      end
    end

    drain();
    $display("run covered %0d items, %0d reports, %0d keep_count writes",
             items_sent, reports_sent, keep_writes);
    $display("%0d reported entries checked, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("top_k_by_divisor_count_tb OK");
    end else begin
      $display("top_k_by_divisor_count_tb NOT OK");
    end
    $finish;
  end

endmodule
